// File: sv/vec3alu_pkg.sv
// Shared types, constants and helper functions of the three-component vector ALU.
package vec3alu_pkg;

  // Number format and derived widths.
  localparam int CW      = 32;            // component width
  localparam int FB      = 16;            // fraction bits
  localparam int NL      = 3;             // vector lanes
  localparam int PW      = 2 * CW;        // exact product width
  localparam int SW      = 2 * CW + 2;    // width of values handed to saturation
  localparam int NW      = 3 * CW;        // dividend width of the quotient unit
  localparam int SQ_STG  = CW;            // square root stages, one root bit each
  localparam int DIV_STG = NW;            // divider stages, one quotient bit each
  localparam int DIV_LAT = DIV_STG + 2;   // two product stages ahead of the divider
  localparam int LAT     = 1 + 2 + 2 + SQ_STG + DIV_LAT + 1;
  localparam int IN_DW   = 7 * CW;
  localparam int OUT_DW  = 4 * CW;
  localparam int FUNC_W  = 4;
  localparam int STAT_W  = 2;

  localparam logic signed [SW-1:0] VMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_MUL   = 4'd3,
    OP_NEG   = 4'd4,
    OP_DOT   = 4'd5,
    OP_CROSS = 4'd6,
    OP_LEN   = 4'd7,
    OP_LEN2  = 4'd8,
    OP_DIST  = 4'd9,
    OP_NORM  = 4'd10,
    OP_CLAMP = 4'd11,
    OP_PROJ  = 4'd12
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    comp_t val;
    logic  ovf;
  } sat_t;

  // What one lane hands to the merging stage.
  typedef struct packed {
    comp_t                  a;
    comp_t                  b;
    comp_t                  add_v;
    comp_t                  sub_v;
    comp_t                  neg_v;
    comp_t                  scale_v;
    comp_t                  mul_v;
    comp_t                  cross_v;
    logic                   add_o;
    logic                   sub_o;
    logic                   neg_o;
    logic                   scale_o;
    logic                   mul_o;
    logic                   cross_o;
    logic signed [PW-1:0]   p_ab;
    logic [PW-1:0]          p_aa;
    logic [PW-1:0]          p_bb;
    logic [PW-1:0]          p_dd;
  } lane_out_t;

  // Partial result and quotient setup ahead of the square root.
  typedef struct packed {
    logic [NL-1:0][CW-1:0]  r;
    logic [CW-1:0]          sc;
    logic                   ovf;
    logic                   div0;
    logic                   use_div;
    logic                   use_len;
    logic                   dsel_b;
    logic [NL-1:0]          neg;
    logic [NL-1:0][PW-1:0]  m;
    logic [NL-1:0][CW-1:0]  k;
    logic [PW-1:0]          sb;
  } pre_t;

  // Partial result carried alongside the dividers.
  typedef struct packed {
    logic [NL-1:0][CW-1:0]  r;
    logic [CW-1:0]          sc;
    logic                   ovf;
    logic                   div0;
    logic                   use_div;
    logic                   use_len;
    logic [NL-1:0]          neg;
    logic [CW-1:0]          root;
  } post_t;

  // Clip a wide signed value to the component range.
  function automatic sat_t sat_cw(input logic signed [SW-1:0] v);
    sat_t res;
    res.val = v[CW-1:0];
    res.ovf = 1'b0;
    if (v > VMAX) begin
      res.val = VMAX[CW-1:0];
      res.ovf = 1'b1;
    end else if (v < VMIN) begin
      res.val = VMIN[CW-1:0];
      res.ovf = 1'b1;
    end
    return res;
  endfunction

  // Magnitude of a component as an unsigned number.
  function automatic logic [CW-1:0] mag_cw(input comp_t x);
    logic [CW-1:0] res;
    res = x[CW-1] ? (~x + 1'b1) : x;
    return res;
  endfunction

endpackage

// File: sv/vec3alu_lane.sv
// One component lane: sums, differences and products of a single vector component.
module vec3alu_lane (
  input  logic                   clk,
  input  logic                   en,
  input  vec3alu_pkg::comp_t     a_i,
  input  vec3alu_pkg::comp_t     b_i,
  input  vec3alu_pkg::comp_t     s_i,
  input  vec3alu_pkg::comp_t     xu_i,
  input  vec3alu_pkg::comp_t     yw_i,
  input  vec3alu_pkg::comp_t     xw_i,
  input  vec3alu_pkg::comp_t     yu_i,
  output vec3alu_pkg::lane_out_t lane_o
);
  import vec3alu_pkg::*;

  logic signed [CW:0]    sum_w;
  logic signed [CW:0]    dif_w;
  logic signed [CW:0]    ngt_w;
  logic signed [PW:0]    crs_w;

  comp_t                 a1_r;
  comp_t                 b1_r;
  sat_t                  add_r;
  sat_t                  sub_r;
  sat_t                  neg_r;
  logic signed [PW-1:0]  p_ab_r;
  logic signed [PW-1:0]  p_as_r;
  logic signed [PW-1:0]  p_c1_r;
  logic signed [PW-1:0]  p_c2_r;
  logic [PW-1:0]         p_aa_r;
  logic [PW-1:0]         p_bb_r;

  lane_out_t             lane_nxt;
  lane_out_t             lane_r;
  sat_t                  scl_w;
  sat_t                  mul_w;
  sat_t                  crs_s;

  // First stage: additions and the products of the raw components.
  assign sum_w = (CW+1)'(a_i) + (CW+1)'(b_i);
  assign dif_w = (CW+1)'(a_i) - (CW+1)'(b_i);
  assign ngt_w = -((CW+1)'(a_i));

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= a_i;
      b1_r   <= b_i;
      add_r  <= sat_cw(SW'(sum_w));
      sub_r  <= sat_cw(SW'(dif_w));
      neg_r  <= sat_cw(SW'(ngt_w));
      p_ab_r <= a_i * b_i;
      p_as_r <= a_i * s_i;
      p_c1_r <= xu_i * yw_i;
      p_c2_r <= xw_i * yu_i;
      p_aa_r <= a_i * a_i;
      p_bb_r <= b_i * b_i;
    end
  end

  // Second stage: floor the products back to Q format and square the difference.
  assign crs_w = (PW+1)'(p_c1_r) - (PW+1)'(p_c2_r);
  assign scl_w = sat_cw(SW'(p_as_r >>> FB));
  assign mul_w = sat_cw(SW'(p_ab_r >>> FB));
  assign crs_s = sat_cw(SW'(crs_w >>> FB));

  always_comb begin
    lane_nxt         = '0;
    lane_nxt.a       = a1_r;
    lane_nxt.b       = b1_r;
    lane_nxt.add_v   = add_r.val;
    lane_nxt.add_o   = add_r.ovf;
    lane_nxt.sub_v   = sub_r.val;
    lane_nxt.sub_o   = sub_r.ovf;
    lane_nxt.neg_v   = neg_r.val;
    lane_nxt.neg_o   = neg_r.ovf;
    lane_nxt.scale_v = scl_w.val;
    lane_nxt.scale_o = scl_w.ovf;
    lane_nxt.mul_v   = mul_w.val;
    lane_nxt.mul_o   = mul_w.ovf;
    lane_nxt.cross_v = crs_s.val;
    lane_nxt.cross_o = crs_s.ovf;
    lane_nxt.p_ab    = p_ab_r;
    lane_nxt.p_aa    = p_aa_r;
    lane_nxt.p_bb    = p_bb_r;
    lane_nxt.p_dd    = sub_r.val * sub_r.val;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

// File: sv/vec3alu_merge.sv
// Merging stage: combines the lanes into dot products, squared lengths and the result select.
module vec3alu_merge (
  input  logic                                 clk,
  input  logic                                 en,
  input  vec3alu_pkg::lane_out_t               lane_i [vec3alu_pkg::NL],
  input  logic [vec3alu_pkg::FUNC_W-1:0]       func_i,
  input  vec3alu_pkg::comp_t                   s_i,
  input  logic [vec3alu_pkg::PW-1:0]           ss_i,
  output vec3alu_pkg::pre_t                    pre_o,
  output logic [vec3alu_pkg::PW-1:0]           rad_o
);
  import vec3alu_pkg::*;

  lane_out_t             lane1_r [NL];
  logic [FUNC_W-1:0]     func1_r;
  comp_t                 s1_r;
  logic [PW-1:0]         ss1_r;
  logic signed [SW-1:0]  dot_r;
  logic [PW-1:0]         sa_r;
  logic [PW-1:0]         sd_r;
  logic [PW-1:0]         sb_r;

  logic signed [SW-1:0]  dot_nxt;
  logic [PW-1:0]         sa_nxt;
  logic [PW-1:0]         sd_nxt;
  logic [PW-1:0]         sb_nxt;

  logic signed [SW-1:0]  dneg_w;
  logic [PW-1:0]         dmag_w;
  pre_t                  pre_nxt;
  pre_t                  pre_r;
  logic [PW-1:0]         rad_nxt;
  logic [PW-1:0]         rad_r;

  // First stage: three-way sums across the lanes.
  always_comb begin
    dot_nxt = '0;
    sa_nxt  = '0;
    sd_nxt  = '0;
    sb_nxt  = '0;
    for (int c = 0; c < NL; c++) begin
      dot_nxt = dot_nxt + SW'(lane_i[c].p_ab);
      sa_nxt  = sa_nxt + lane_i[c].p_aa;
      sd_nxt  = sd_nxt + lane_i[c].p_dd;
      sb_nxt  = sb_nxt + lane_i[c].p_bb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane1_r <= lane_i;
      func1_r <= func_i;
      s1_r    <= s_i;
      ss1_r   <= ss_i;
      dot_r   <= dot_nxt;
      sa_r    <= sa_nxt;
      sd_r    <= sd_nxt;
      sb_r    <= sb_nxt;
    end
  end

  assign dneg_w = -dot_r;
  assign dmag_w = dot_r[SW-1] ? dneg_w[PW-1:0] : dot_r[PW-1:0];

  // Second stage: pick the result for the opcode and set up any division.
  always_comb begin
    sat_t tmp;
    pre_nxt    = '0;
    pre_nxt.sb = sb_r;
    tmp        = '0;
    case (op_t'(func1_r))
      OP_ADD: begin
        for (int c = 0; c < NL; c++) begin
          pre_nxt.r[c] = lane1_r[c].add_v;
          pre_nxt.ovf  = pre_nxt.ovf | lane1_r[c].add_o;
        end
      end
      OP_SUB: begin
        for (int c = 0; c < NL; c++) begin
          pre_nxt.r[c] = lane1_r[c].sub_v;
          pre_nxt.ovf  = pre_nxt.ovf | lane1_r[c].sub_o;
        end
      end
      OP_SCALE: begin
        for (int c = 0; c < NL; c++) begin
          pre_nxt.r[c] = lane1_r[c].scale_v;
          pre_nxt.ovf  = pre_nxt.ovf | lane1_r[c].scale_o;
        end
      end
      OP_MUL: begin
        for (int c = 0; c < NL; c++) begin
          pre_nxt.r[c] = lane1_r[c].mul_v;
          pre_nxt.ovf  = pre_nxt.ovf | lane1_r[c].mul_o;
        end
      end
      OP_NEG: begin
        for (int c = 0; c < NL; c++) begin
          pre_nxt.r[c] = lane1_r[c].neg_v;
          pre_nxt.ovf  = pre_nxt.ovf | lane1_r[c].neg_o;
        end
      end
      OP_CROSS: begin
        for (int c = 0; c < NL; c++) begin
          pre_nxt.r[c] = lane1_r[c].cross_v;
          pre_nxt.ovf  = pre_nxt.ovf | lane1_r[c].cross_o;
        end
      end
      OP_DOT: begin
        tmp         = sat_cw(dot_r >>> FB);
        pre_nxt.sc  = tmp.val;
        pre_nxt.ovf = tmp.ovf;
      end
      OP_LEN: begin
        pre_nxt.use_len = 1'b1;
      end
      OP_LEN2: begin
        tmp         = sat_cw({2'b00, sa_r} >> FB);
        pre_nxt.sc  = tmp.val;
        pre_nxt.ovf = tmp.ovf;
      end
      OP_DIST: begin
        pre_nxt.use_len = 1'b1;
        for (int c = 0; c < NL; c++) begin
          pre_nxt.ovf = pre_nxt.ovf | lane1_r[c].sub_o;
        end
      end
      OP_NORM: begin
        if (sa_r == '0) begin
          pre_nxt.div0 = 1'b1;
        end else begin
          pre_nxt.use_div = 1'b1;
          for (int c = 0; c < NL; c++) begin
            pre_nxt.m[c]  = PW'(mag_cw(lane1_r[c].a));
            pre_nxt.k[c]  = CW'(1) << FB;
            pre_nxt.neg[c] = lane1_r[c].a[CW-1];
          end
        end
      end
      OP_CLAMP: begin
        if (sa_r > ss1_r) begin
          pre_nxt.use_div = 1'b1;
          for (int c = 0; c < NL; c++) begin
            pre_nxt.m[c]   = PW'(mag_cw(lane1_r[c].a));
            pre_nxt.k[c]   = mag_cw(s1_r);
            pre_nxt.neg[c] = lane1_r[c].a[CW-1] ^ s1_r[CW-1];
          end
        end else begin
          for (int c = 0; c < NL; c++) begin
            pre_nxt.r[c] = lane1_r[c].a;
          end
        end
      end
      OP_PROJ: begin
        if (sb_r == '0) begin
          pre_nxt.div0 = 1'b1;
        end else begin
          pre_nxt.use_div = 1'b1;
          pre_nxt.dsel_b  = 1'b1;
          for (int c = 0; c < NL; c++) begin
            pre_nxt.m[c]   = dmag_w;
            pre_nxt.k[c]   = mag_cw(lane1_r[c].b);
            pre_nxt.neg[c] = dot_r[SW-1] ^ lane1_r[c].b[CW-1];
          end
        end
      end
      default: begin
        pre_nxt.sb = sb_r;
      end
    endcase
    rad_nxt = (op_t'(func1_r) == OP_DIST) ? sd_r : sa_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
      rad_r <= rad_nxt;
    end
  end

  assign pre_o = pre_r;
  assign rad_o = rad_r;

endmodule

// File: sv/vec3alu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module vec3alu_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [vec3alu_pkg::PW-1:0]   rad_i,
  output logic [vec3alu_pkg::CW-1:0]   root_o
);
  import vec3alu_pkg::*;

  logic [PW-1:0] n_r [SQ_STG];
  logic [PW-1:0] r_r [SQ_STG];

  for (genvar i = 0; i < SQ_STG; i++) begin : g_stg
    localparam logic [PW-1:0] BIT = PW'(1) << (2 * (SQ_STG - 1 - i));
    logic [PW-1:0] n_in;
    logic [PW-1:0] r_in;
    logic [PW:0]   t_w;
    logic          ge_w;
    logic [PW-1:0] n_nxt;
    logic [PW-1:0] r_nxt;

    if (i == 0) begin : g_first
      assign n_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_r[i-1];
      assign r_in = r_r[i-1];
    end

    // Try the next root bit and keep it when the remainder allows.
    assign t_w   = {1'b0, r_in} + {1'b0, BIT};
    assign ge_w  = {1'b0, n_in} >= t_w;
    assign n_nxt = ge_w ? (n_in - t_w[PW-1:0]) : n_in;
    assign r_nxt = ge_w ? ((r_in >> 1) + BIT) : (r_in >> 1);

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i] <= n_nxt;
        r_r[i] <= r_nxt;
      end
    end
  end

  assign root_o = r_r[SQ_STG-1][CW-1:0];

endmodule

// File: sv/vec3alu_div.sv
// Per-lane quotient unit: split product m*k, then a restoring divider one bit per stage.
module vec3alu_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [vec3alu_pkg::PW-1:0]   m_i,
  input  logic [vec3alu_pkg::CW-1:0]   k_i,
  input  logic [vec3alu_pkg::PW-1:0]   d_i,
  output logic [vec3alu_pkg::PW-1:0]   q_o
);
  import vec3alu_pkg::*;

  logic [PW-1:0] pl_r;
  logic [PW-1:0] ph_r;
  logic [PW-1:0] d1_r;
  logic [NW-1:0] num_r;
  logic [PW-1:0] d2_r;

  logic [PW-1:0] rem_r [DIV_STG];
  logic [NW-1:0] nq_r  [DIV_STG];
  logic [PW-1:0] dd_r  [DIV_STG];

  // Product in two halves, then their sum.
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r  <= m_i[CW-1:0] * k_i;
      ph_r  <= m_i[PW-1:CW] * k_i;
      d1_r  <= d_i;
      num_r <= {ph_r, {CW{1'b0}}} + NW'(pl_r);
      d2_r  <= d1_r;
    end
  end

  for (genvar i = 0; i < DIV_STG; i++) begin : g_stg
    logic [PW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [PW-1:0] d_in;
    logic [PW:0]   t_w;
    logic [PW:0]   dif_w;
    logic          ge_w;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_r;
      assign d_in   = d2_r;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign d_in   = dd_r[i-1];
    end

    // Shift in the next dividend bit and subtract when it fits.
    assign t_w   = {rem_in, nq_in[NW-1]};
    assign dif_w = t_w - {1'b0, d_in};
    assign ge_w  = t_w >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge_w ? dif_w[PW-1:0] : t_w[PW-1:0];
        nq_r[i]  <= {nq_in[NW-2:0], ge_w};
        dd_r[i]  <= d_in;
      end
    end
  end

  assign q_o = nq_r[DIV_STG-1][PW-1:0];

endmodule

// File: sv/vec3_vector_alu_top.sv
// Top level of the three-component vector ALU in signed Q16.16.
//
// The input channel carries one item per operation: opcode on in_tuser, vectors a and b
// and a scalar on in_tdata. The result channel carries the vector result, the scalar
// result and a status (ok, divide by zero length, saturated) for every accepted item.
// Each item passes through an input register, three component lanes (two stages), a
// merging stage (two stages), a 32-stage square root, three 98-stage quotient units
// and an output register, with every opcode taking the same path so results leave in order.
// The pipeline takes one item per clock while the output is free or being taken; the
// depth of the bit-serial square root and divider stages sets the latency.
// When the receiver holds out_tready low with a result waiting, the whole pipeline
// freezes and in_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears only the valid flags of the pipeline stages; data stages need none.
module vec3_vector_alu_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
  input  logic [vec3alu_pkg::IN_DW-1:0]      in_tdata,
  // func
  input  logic [vec3alu_pkg::FUNC_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // r_x, r_y, r_z, scalar_out
  output logic [vec3alu_pkg::OUT_DW-1:0]     out_tdata,
  // status
  output logic [vec3alu_pkg::STAT_W-1:0]     out_tuser
);
  import vec3alu_pkg::*;

  logic                  en;
  logic [LAT-1:0]        vld_r;

  logic [FUNC_W-1:0]     func_a_r;
  comp_t                 a_a_r [NL];
  comp_t                 b_a_r [NL];
  comp_t                 s_a_r;

  logic [FUNC_W-1:0]     func1_r;
  comp_t                 s1_r;
  logic [PW-1:0]         ss1_r;
  logic [FUNC_W-1:0]     func2_r;
  comp_t                 s2_r;
  logic [PW-1:0]         ss2_r;

  lane_out_t             lane_w [NL];
  pre_t                  pre_w;
  logic [PW-1:0]         rad_w;
  logic [CW-1:0]         root_w;
  pre_t                  pre_d_r [SQ_STG];
  post_t                 post_nxt;
  post_t                 post_d_r [DIV_LAT];
  logic [PW-1:0]         den_w;
  logic [PW-1:0]         q_w [NL];

  logic [OUT_DW-1:0]     out_data_nxt;
  logic [STAT_W-1:0]     out_stat_nxt;
  logic [OUT_DW-1:0]     out_data_r;
  logic [STAT_W-1:0]     out_stat_r;

  // The whole pipeline moves whenever the output register is free or being taken.
  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (en) begin
      func_a_r <= in_tuser;
      for (int c = 0; c < NL; c++) begin
        a_a_r[c] <= in_tdata[c*CW +: CW];
        b_a_r[c] <= in_tdata[(NL+c)*CW +: CW];
      end
      s_a_r <= in_tdata[2*NL*CW +: CW];
    end
  end

  // Opcode and scalar travel beside the lanes; the squared scalar is formed here.
  always_ff @(posedge clk) begin
    if (en) begin
      func1_r <= func_a_r;
      s1_r    <= s_a_r;
      ss1_r   <= s_a_r * s_a_r;
      func2_r <= func1_r;
      s2_r    <= s1_r;
      ss2_r   <= ss1_r;
    end
  end

  for (genvar c = 0; c < NL; c++) begin : g_lane
    vec3alu_lane u_lane (
      .clk    (clk),
      .en     (en),
      .a_i    (a_a_r[c]),
      .b_i    (b_a_r[c]),
      .s_i    (s_a_r),
      .xu_i   (a_a_r[(c+1)%NL]),
      .yw_i   (b_a_r[(c+2)%NL]),
      .xw_i   (a_a_r[(c+2)%NL]),
      .yu_i   (b_a_r[(c+1)%NL]),
      .lane_o (lane_w[c])
    );
  end

  vec3alu_merge u_merge (
    .clk    (clk),
    .en     (en),
    .lane_i (lane_w),
    .func_i (func2_r),
    .s_i    (s2_r),
    .ss_i   (ss2_r),
    .pre_o  (pre_w),
    .rad_o  (rad_w)
  );

  vec3alu_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  (rad_w),
    .root_o (root_w)
  );

  // Partial results wait beside the square root.
  always_ff @(posedge clk) begin
    if (en) begin
      pre_d_r[0] <= pre_w;
      for (int i = 1; i < SQ_STG; i++) begin
        pre_d_r[i] <= pre_d_r[i-1];
      end
    end
  end

  assign den_w = pre_d_r[SQ_STG-1].dsel_b ? pre_d_r[SQ_STG-1].sb : PW'(root_w);

  for (genvar c = 0; c < NL; c++) begin : g_div
    vec3alu_div u_div (
      .clk (clk),
      .en  (en),
      .m_i (pre_d_r[SQ_STG-1].m[c]),
      .k_i (pre_d_r[SQ_STG-1].k[c]),
      .d_i (den_w),
      .q_o (q_w[c])
    );
  end

  // Partial results wait beside the quotient units.
  always_comb begin
    post_nxt         = '0;
    post_nxt.r       = pre_d_r[SQ_STG-1].r;
    post_nxt.sc      = pre_d_r[SQ_STG-1].sc;
    post_nxt.ovf     = pre_d_r[SQ_STG-1].ovf;
    post_nxt.div0    = pre_d_r[SQ_STG-1].div0;
    post_nxt.use_div = pre_d_r[SQ_STG-1].use_div;
    post_nxt.use_len = pre_d_r[SQ_STG-1].use_len;
    post_nxt.neg     = pre_d_r[SQ_STG-1].neg;
    post_nxt.root    = root_w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      post_d_r[0] <= post_nxt;
      for (int i = 1; i < DIV_LAT; i++) begin
        post_d_r[i] <= post_d_r[i-1];
      end
    end
  end

  // Final merge: signed quotients, root as scalar, status.
  always_comb begin
    post_t          pst;
    logic [PW-1:0]  qs;
    sat_t           tmp;
    logic           ovf;
    pst = post_d_r[DIV_LAT-1];
    ovf = pst.ovf;
    qs  = '0;
    tmp = '0;
    out_data_nxt = '0;
    for (int c = 0; c < NL; c++) begin
      qs  = pst.neg[c] ? (~q_w[c] + 1'b1) : q_w[c];
      tmp = sat_cw(SW'($signed(qs)));
      if (pst.use_div) begin
        out_data_nxt[c*CW +: CW] = tmp.val;
        ovf = ovf | tmp.ovf;
      end else begin
        out_data_nxt[c*CW +: CW] = pst.r[c];
      end
    end
    if (pst.use_len) begin
      tmp = sat_cw(SW'(pst.root));
      out_data_nxt[NL*CW +: CW] = tmp.val;
      ovf = ovf | tmp.ovf;
    end else begin
      out_data_nxt[NL*CW +: CW] = pst.sc;
    end
    if (pst.div0) begin
      out_stat_nxt = ST_DIV0;
    end else if (ovf) begin
      out_stat_nxt = ST_SAT;
    end else begin
      out_stat_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_stat_r <= out_stat_nxt;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule

// File: sv/vec3alu_checker.sv
// Port-level checks of the vector ALU and their binding to the top level.
module vec3alu_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [vec3alu_pkg::IN_DW-1:0]      in_tdata,
  input  logic [vec3alu_pkg::FUNC_W-1:0]     in_tuser,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [vec3alu_pkg::OUT_DW-1:0]     out_tdata,
  input  logic [vec3alu_pkg::STAT_W-1:0]     out_tuser
);
  import vec3alu_pkg::*;

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // The input side only waits while a result is stalled.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow the output stall");

  // Status is always one of the defined codes.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_DIV0 || out_tuser == ST_SAT))
    else $error("undefined status code");

  // A divide by zero length gives all-zero results.
  a_div0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_DIV0 |-> out_tdata == '0)
    else $error("nonzero result with divide by zero status");

endmodule

bind vec3_vector_alu_top vec3alu_checker u_vec3alu_checker (.*);

// File: test/tb_top.sv
// Self-checking testbench for the three-component vector ALU (directed table, then random).
`timescale 1ns / 100ps

module tb_top;
  import vec3alu_pkg::*;

  typedef logic signed [127:0] wide_t;

  // Opcodes above the defined set must come back as all zeros.
  localparam logic [FUNC_W-1:0] OP_UNDEF_LO  = 4'd13;
  localparam logic [FUNC_W-1:0] OP_UNDEF_MID = 4'd14;
  localparam logic [FUNC_W-1:0] OP_UNDEF_HI  = 4'd15;

  localparam comp_t ONE  = 32'sh0001_0000;
  localparam comp_t MAXV = 32'sh7fff_ffff;
  localparam comp_t MINV = 32'sh8000_0000;
  localparam int    PIPE_DEPTH = LAT;

  // One input item plus an optional hand-written answer.
  typedef struct {
    logic [FUNC_W-1:0] f;
    comp_t ax, ay, az, bx, by, bz, s;
    bit    known;
    comp_t rx, ry, rz, sc;
    logic [STAT_W-1:0] st;
  } vec_item_t;

  typedef struct {
    comp_t rx, ry, rz, sc;
    logic [STAT_W-1:0] st;
  } vec_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata = '0;
  logic [FUNC_W-1:0]   in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic [STAT_W-1:0]   out_tuser;

  vec_result_t results_due[$];
  vec_item_t   directed_rows[$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          op_hits[16];
  int          burst_left = 0;

  vec3_vector_alu_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #10 clk = ~clk;

  // Saturate a wide value to the component range and flag the overflow.
  function automatic comp_t clip(input wide_t v, inout logic ovf);
    if (v > wide_t'(MAXV)) begin
      ovf = 1'b1;
      return MAXV;
    end
    if (v < wide_t'(MINV)) begin
      ovf = 1'b1;
      return MINV;
    end
    return comp_t'(v[CW-1:0]);
  endfunction

  // Floor of the integer square root, one result bit per pass.
  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] probe;
    r = '0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= r + probe) begin
        n = n - (r + probe);
        r = (r >> 1) + probe;
      end else begin
        r = r >> 1;
      end
      probe = probe >> 2;
    end
    return r;
  endfunction

  function automatic wide_t sq3(input wide_t x, input wide_t y, input wide_t z);
    return x * x + y * y + z * z;
  endfunction

  // Expected answer of the vector unit for one item.
  function automatic vec_result_t vec_alu_eval(input vec_item_t it);
    vec_result_t res;
    wide_t a[3], b[3], d[3], r[3];
    wide_t s, len, sum, den, nm, q, bm;
    logic ovf;
    logic div0;
    logic nneg;
    comp_t dc;
    a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
    b[0] = it.bx; b[1] = it.by; b[2] = it.bz;
    s = it.s;
    ovf = 1'b0;
    div0 = 1'b0;
    res = '{default: '0};
    for (int c = 0; c < 3; c++) r[c] = 0;
    sum = 0;
    case (it.f)
      OP_ADD:   for (int c = 0; c < 3; c++) r[c] = a[c] + b[c];
      OP_SUB:   for (int c = 0; c < 3; c++) r[c] = a[c] - b[c];
      OP_SCALE: for (int c = 0; c < 3; c++) r[c] = (a[c] * s) >>> FB;
      OP_MUL:   for (int c = 0; c < 3; c++) r[c] = (a[c] * b[c]) >>> FB;
      OP_NEG:   for (int c = 0; c < 3; c++) r[c] = -a[c];
      OP_DOT:   sum = (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FB;
      OP_CROSS: for (int c = 0; c < 3; c++)
                  r[c] = (a[(c + 1) % 3] * b[(c + 2) % 3] - a[(c + 2) % 3] * b[(c + 1) % 3])
                         >>> FB;
      OP_LEN:   sum = root64(sq3(a[0], a[1], a[2]));
      OP_LEN2:  sum = sq3(a[0], a[1], a[2]) >>> FB;
      OP_DIST: begin
        // The difference saturates per component before its length is taken.
        for (int c = 0; c < 3; c++) begin
          dc = clip(a[c] - b[c], ovf);
          d[c] = dc;
        end
        sum = root64(sq3(d[0], d[1], d[2]));
      end
      OP_NORM: begin
        len = root64(sq3(a[0], a[1], a[2]));
        if (len == 0) div0 = 1'b1;
        else for (int c = 0; c < 3; c++) r[c] = (a[c] <<< FB) / len;
      end
      OP_CLAMP: begin
        if (sq3(a[0], a[1], a[2]) > s * s) begin
          len = root64(sq3(a[0], a[1], a[2]));
          for (int c = 0; c < 3; c++) r[c] = (a[c] * s) / len;
        end else begin
          for (int c = 0; c < 3; c++) r[c] = a[c];
        end
      end
      OP_PROJ: begin
        den = sq3(b[0], b[1], b[2]);
        if (den == 0) begin
          div0 = 1'b1;
        end else begin
          nm = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
          nneg = nm < 0;
          if (nneg) nm = -nm;
          // Quotients truncate toward zero, so work on magnitudes.
          for (int c = 0; c < 3; c++) begin
            bm = b[c] < 0 ? -b[c] : b[c];
            q = (nm * bm) / den;
            r[c] = (nneg != (b[c] < 0)) ? -q : q;
          end
        end
      end
      default: ;
    endcase
    // A zero length gives all-zero fields with the divide-by-zero status.
    if (div0) begin
      res.st = ST_DIV0;
      return res;
    end
    res.rx = clip(r[0], ovf);
    res.ry = clip(r[1], ovf);
    res.rz = clip(r[2], ovf);
    res.sc = clip(sum, ovf);
    res.st = ovf ? ST_SAT : ST_OK;
    return res;
  endfunction

  // Random component: small values most often, some full range and extremes.
  function automatic comp_t pick_comp();
    case ($urandom_range(0, 9))
      0, 1:    return comp_t'($urandom);
      2:       return MAXV;
      3:       return MINV;
      4:       return '0;
      5:       return comp_t'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      default: return comp_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  // Hand one item to the block, hold it until taken, then log its answer.
  task automatic send_item(input vec_item_t it);
    vec_result_t exp_res;
    in_tvalid <= 1'b1;
    in_tuser  <= it.f;
    in_tdata  <= {it.s, it.bz, it.by, it.bx, it.az, it.ay, it.ax};
    do @(posedge clk); while (!in_tready);
    if (it.known) exp_res = '{it.rx, it.ry, it.rz, it.sc, it.st};
    else exp_res = vec_alu_eval(it);
    results_due.push_back(exp_res);
    items_sent++;
    op_hits[it.f]++;
    @(negedge clk);
    // Bursts of back-to-back items, separated by random gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // Receiver stalls in phases: always ready, coin flip, or mostly held off.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Compare each delivered result with the oldest expectation.
  always @(posedge clk) begin
    vec_result_t want;
    comp_t got_x, got_y, got_z, got_s;
    if (rst_n && out_tvalid && out_tready) begin
      {got_s, got_z, got_y, got_x} = out_tdata;
      results_seen++;
      if (results_due.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        want = results_due.pop_front();
        if (got_x !== want.rx) begin
          $error("r_x expected %h got %h", want.rx, got_x);
          errors++;
        end
        if (got_y !== want.ry) begin
          $error("r_y expected %h got %h", want.ry, got_y);
          errors++;
        end
        if (got_z !== want.rz) begin
          $error("r_z expected %h got %h", want.rz, got_z);
          errors++;
        end
        if (got_s !== want.sc) begin
          $error("scalar_out expected %h got %h", want.sc, got_s);
          errors++;
        end
        if (out_tuser !== want.st) begin
          $error("status expected %0d got %0d", want.st, out_tuser);
          errors++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    vec_item_t it;
    int n_rand;
    foreach (op_hits[i]) op_hits[i] = 0;

    // Directed table; rows marked known carry their answer.
    directed_rows = '{
      '{OP_ADD, ONE, 2*ONE, 3*ONE, ONE, ONE, ONE, 0, 1, 2*ONE, 3*ONE, 4*ONE, 0, ST_OK},
      '{OP_ADD, MAXV, 0, 0, ONE, 0, 0, 0, 1, MAXV, 0, 0, 0, ST_SAT},
      '{OP_SUB, MINV, 0, 0, ONE, 0, 0, 0, 1, MINV, 0, 0, 0, ST_SAT},
      '{OP_NEG, MINV, MAXV, 0, 0, 0, 0, 0, 1, MAXV, MINV + 1, 0, 0, ST_SAT},
      '{OP_DOT, ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 0, 1, 0, 0, 0, 32*ONE, ST_OK},
      '{OP_LEN, 3*ONE, 4*ONE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 5*ONE, ST_OK},
      '{OP_LEN, MAXV, MINV, MAXV, 0, 0, 0, 0, 1, 0, 0, 0, MAXV, ST_SAT},
      '{OP_LEN2, ONE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, ONE, ST_OK},
      '{OP_NORM, 0, 0, 0, ONE, ONE, ONE, ONE, 1, 0, 0, 0, 0, ST_DIV0},
      '{OP_PROJ, ONE, ONE, ONE, 0, 0, 0, 0, 1, 0, 0, 0, 0, ST_DIV0},
      '{OP_UNDEF_LO, MAXV, MINV, ONE, ONE, MINV, MAXV, MAXV, 1, 0, 0, 0, 0, ST_OK},
      '{OP_UNDEF_HI, -1, -1, -1, -1, -1, -1, -1, 1, 0, 0, 0, 0, ST_OK},
      '{OP_UNDEF_MID, ONE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, ST_OK},
      '{OP_SCALE, -3*ONE, ONE/2, MAXV, 0, 0, 0, -ONE - 1, 0, 0, 0, 0, 0, ST_OK},
      '{OP_MUL, MINV, -ONE, 3, MINV, -1, -7, 0, 0, 0, 0, 0, 0, ST_OK},
      '{OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{OP_CROSS, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0, 0, 0, 0, 0, 0, ST_OK},
      '{OP_DIST, MINV, 0, 1, MAXV, 0, -1, 0, 0, 0, 0, 0, 0, ST_OK},
      '{OP_DIST, ONE, 2*ONE, 2*ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{OP_NORM, 3*ONE, -4*ONE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{OP_NORM, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK},
      '{OP_CLAMP, 3*ONE, 4*ONE, 0, 0, 0, 0, -2*ONE, 0, 0, 0, 0, 0, ST_OK},
      '{OP_CLAMP, ONE, ONE, 0, 0, 0, 0, 5*ONE, 0, 0, 0, 0, 0, ST_OK},
      '{OP_CLAMP, MINV, MINV, MINV, 0, 0, 0, MINV, 0, 0, 0, 0, 0, ST_OK},
      '{OP_PROJ, MAXV, MINV, MAXV, 1, -1, 0, 0, 0, 0, 0, 0, 0, ST_OK}
    };

    // Synchronous reset, released at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    // Let the pipeline empty completely before the random part.
    drain();

    n_rand = 1825;
    for (int i = 0; i < n_rand; i++) begin
      it.known = 1'b0;
      it.f = ($urandom_range(0, 19) == 0) ? FUNC_W'($urandom_range(13, 15))
                                           : FUNC_W'($urandom_range(0, 12));
      it.ax = pick_comp(); it.ay = pick_comp(); it.az = pick_comp();
      it.bx = pick_comp(); it.by = pick_comp(); it.bz = pick_comp();
      it.s  = pick_comp();
      // Zero vectors now and then to reach the divide-by-zero path.
      if ($urandom_range(0, 24) == 0) begin
        it.ax = '0; it.ay = '0; it.az = '0;
      end
      if ($urandom_range(0, 24) == 0) begin
        it.bx = '0; it.by = '0; it.bz = '0;
      end
      send_item(it);
      if (i == n_rand / 2) drain();
    end

    drain();
    repeat (PIPE_DEPTH + 20) @(negedge clk);

    $display("Covered %0d items (%0d results): add %0d sub %0d scale %0d mul %0d neg %0d",
             items_sent, results_seen, op_hits[0], op_hits[1], op_hits[2], op_hits[3],
             op_hits[4]);
    $display("dot %0d cross %0d len %0d len2 %0d dist %0d norm %0d clamp %0d proj %0d",
             op_hits[5], op_hits[6], op_hits[7], op_hits[8], op_hits[9], op_hits[10],
             op_hits[11], op_hits[12]);
    if (errors == 0 && results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
